[src/gn3_pkg.sv]
`default_nettype none
package gn3_pkg;

    localparam int TABLE_SIZE    = 256;
    localparam int CELL_W        = 8;
    localparam int COORD_W       = 32;
    localparam int OUT_W         = 16;
    localparam int FRAC_BITS_DEF = 16;

    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_EVAL  = 1'b1
    } t_cmd;

    // Table request presented by the top level at the accept edge.
    typedef struct packed {
        logic              load;
        t_cmd              command;
        logic [CELL_W-1:0] table_index;
        logic [CELL_W-1:0] table_value;
        logic [CELL_W-1:0] cell_x;
        logic [CELL_W-1:0] cell_y;
        logic [CELL_W-1:0] cell_z;
    } t_tbl_req;

endpackage
`default_nettype wire

[src/gn3_if.sv]
`default_nettype none
interface gn3_in_if
    import gn3_pkg::*;
();
    logic                      valid;
    logic                      ready;
    t_cmd                      command;
    logic [CELL_W-1:0]         table_index;
    logic [CELL_W-1:0]         table_value;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;

    modport source (output valid, command, table_index, table_value, coord_x, coord_y,
                    coord_z, input ready);
    modport sink (input valid, command, table_index, table_value, coord_x, coord_y,
                  coord_z, output ready);
endinterface

interface gn3_out_if
    import gn3_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] noise_value;

    modport source (output valid, noise_value, input ready);
    modport sink (input valid, noise_value, output ready);
endinterface
`default_nettype wire

[src/gn3_ram.sv]
`default_nettype none
module gn3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr0,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr1,
    output logic      [WIDTH-1:0]         o_rdata0,
    output logic      [WIDTH-1:0]         o_rdata1
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata0 <= r_mem[i_raddr0];
            o_rdata1 <= r_mem[i_raddr1];
        end
    end
endmodule
`default_nettype wire

[src/gn3_hash.sv]
`default_nettype none
module gn3_hash
    import gn3_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire t_tbl_req          i_req,
    output logic [CELL_W-1:0]      o_hash [8]
);
    localparam int AW = $clog2(TABLE_SIZE);

    // Each table copy is written when the write item passes the stage that reads it,
    // so reads and writes keep the item order.
    logic              r_w1, r_w2;
    logic [CELL_W-1:0] r_idx1, r_val1, r_idx2, r_val2;
    logic [CELL_W-1:0] r_cy1, r_cz1, r_cz2;
    logic [CELL_W-1:0] p1 [2];
    logic [CELL_W-1:0] p2 [4];
    logic [CELL_W-1:0] a1, b1;
    logic [CELL_W-1:0] c2 [4];
    logic              wr0;

    assign wr0 = i_req.load && (i_req.command == CMD_WRITE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w1 <= 1'b0;
            r_w2 <= 1'b0;
        end else if (i_en) begin
            r_w1 <= wr0;
            r_w2 <= r_w1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_idx1 <= i_req.table_index;
            r_val1 <= i_req.table_value;
            r_cy1  <= i_req.cell_y;
            r_cz1  <= i_req.cell_z;
            r_idx2 <= r_idx1;
            r_val2 <= r_val1;
            r_cz2  <= r_cz1;
        end
    end

    gn3_ram #(.WIDTH(CELL_W), .DEPTH(TABLE_SIZE)) u_ram1 (
        .i_clk   (i_clk),
        .i_we    (wr0),
        .i_waddr (i_req.table_index[AW-1:0]),
        .i_wdata (i_req.table_value),
        .i_re    (i_en),
        .i_raddr0(i_req.cell_x[AW-1:0]),
        .i_raddr1(AW'(i_req.cell_x + 8'd1)),
        .o_rdata0(p1[0]),
        .o_rdata1(p1[1])
    );

    assign a1 = p1[0] + r_cy1;
    assign b1 = p1[1] + r_cy1;

    gn3_ram #(.WIDTH(CELL_W), .DEPTH(TABLE_SIZE)) u_ram2a (
        .i_clk   (i_clk),
        .i_we    (i_en && r_w1),
        .i_waddr (r_idx1[AW-1:0]),
        .i_wdata (r_val1),
        .i_re    (i_en),
        .i_raddr0(a1[AW-1:0]),
        .i_raddr1(AW'(a1 + 8'd1)),
        .o_rdata0(p2[0]),
        .o_rdata1(p2[1])
    );

    gn3_ram #(.WIDTH(CELL_W), .DEPTH(TABLE_SIZE)) u_ram2b (
        .i_clk   (i_clk),
        .i_we    (i_en && r_w1),
        .i_waddr (r_idx1[AW-1:0]),
        .i_wdata (r_val1),
        .i_re    (i_en),
        .i_raddr0(b1[AW-1:0]),
        .i_raddr1(AW'(b1 + 8'd1)),
        .o_rdata0(p2[2]),
        .o_rdata1(p2[3])
    );

    // Corner rows in the order aa, ab, ba, bb.
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            c2[k] = p2[k] + r_cz2;
        end
    end

    for (genvar g = 0; g < 4; g++) begin : g_ram3
        gn3_ram #(.WIDTH(CELL_W), .DEPTH(TABLE_SIZE)) u_ram3 (
            .i_clk   (i_clk),
            .i_we    (i_en && r_w2),
            .i_waddr (r_idx2[AW-1:0]),
            .i_wdata (r_val2),
            .i_re    (i_en),
            .i_raddr0(c2[g][AW-1:0]),
            .i_raddr1(AW'(c2[g] + 8'd1)),
            .o_rdata0(o_hash[2*g]),
            .o_rdata1(o_hash[2*g+1])
        );
    end
endmodule
`default_nettype wire

[src/gn3_fade.sv]
`default_nettype none
module gn3_fade #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_en,
    input  wire logic [FRAC_BITS-1:0]       i_frac,
    output logic      [FRAC_BITS-1:0]       o_frac3,
    output logic signed [FRAC_BITS+1:0]     o_fade
);
    localparam int F  = FRAC_BITS;
    localparam int IW = F + 6;
    localparam logic signed [IW-1:0] C_ONE = IW'(1) <<< F;

    logic [F-1:0]           r_t1, r_t2, r_tt2, r_cube3;
    logic signed [IW-1:0]   r_inner2, r_inner3;
    logic signed [IW-1:0]   t1s, a1, inner1;
    logic signed [2*IW-1:0] p1;
    logic [2*F-1:0]         sq1, cu2;
    logic signed [F+IW:0]   f3;

    assign t1s    = $signed({6'b0, r_t1});
    assign a1     = (t1s <<< 2) + (t1s <<< 1) - 15 * C_ONE;
    assign p1     = a1 * t1s;
    assign inner1 = IW'(p1 >>> F) + 10 * C_ONE;
    assign sq1    = r_t1 * r_t1;
    assign cu2    = r_tt2 * r_t2;
    assign f3     = $signed({1'b0, r_cube3}) * r_inner3;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t1     <= i_frac;
            r_t2     <= r_t1;
            r_tt2    <= sq1[2*F-1:F];
            r_inner2 <= inner1;
            o_frac3  <= r_t2;
            r_cube3  <= cu2[2*F-1:F];
            r_inner3 <= r_inner2;
            o_fade   <= (F+2)'(f3 >>> F);
        end
    end
endmodule
`default_nettype wire

[src/gn3_blend.sv]
`default_nettype none
module gn3_blend
    import gn3_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_en,
    input  wire logic [CELL_W-1:0]        i_hash [8],
    input  wire logic [FRAC_BITS-1:0]     i_fx,
    input  wire logic [FRAC_BITS-1:0]     i_fy,
    input  wire logic [FRAC_BITS-1:0]     i_fz,
    input  wire logic signed [FRAC_BITS+1:0] i_u,
    input  wire logic signed [FRAC_BITS+1:0] i_v,
    input  wire logic signed [FRAC_BITS+1:0] i_w,
    output logic [OUT_W-1:0]              o_noise
);
    localparam int F   = FRAC_BITS;
    localparam int W   = F + 4;
    localparam int RW  = W + 9;
    localparam int SHR = (F >= 15) ? F - 15 : 0;
    localparam int SHL = (F < 15) ? 15 - F : 0;
    localparam logic signed [W-1:0] C_ONE = W'(1) <<< F;

    function automatic logic signed [W-1:0] grad(input logic [CELL_W-1:0] h,
                                                 input logic signed [W-1:0] x,
                                                 input logic signed [W-1:0] y,
                                                 input logic signed [W-1:0] z);
        logic [3:0]           h4;
        logic signed [W-1:0]  gu, gv;
        h4 = h[3:0];
        gu = (h4 < 4'd8) ? x : y;
        gv = (h4 < 4'd4) ? y : ((h4 == 4'd12 || h4 == 4'd14) ? x : z);
        return (h4[0] ? -gu : gu) + (h4[1] ? -gv : gv);
    endfunction

    function automatic logic signed [W-1:0] lerp(input logic signed [F+1:0] t,
                                                 input logic signed [W-1:0] a,
                                                 input logic signed [W-1:0] b);
        logic signed [W:0]     d;
        logic signed [F+W+2:0] p;
        d = {b[W-1], b} - {a[W-1], a};
        p = t * d;
        return a + W'(p >>> F);
    endfunction

    logic signed [W-1:0] x0, y0, z0, x1, y1, z1;
    logic signed [W-1:0] g3 [8];
    logic signed [W-1:0] r_g4 [8];
    logic signed [W-1:0] r_l5 [4];
    logic signed [W-1:0] r_lo6, r_hi6;
    logic signed [F+1:0] r_v5, r_w5, r_w6;
    logic signed [W-1:0] n6;
    logic signed [RW-1:0] s6, sh6;

    assign x0 = $signed({4'b0, i_fx});
    assign y0 = $signed({4'b0, i_fy});
    assign z0 = $signed({4'b0, i_fz});
    assign x1 = x0 - C_ONE;
    assign y1 = y0 - C_ONE;
    assign z1 = z0 - C_ONE;

    // Hash order: aa, aa+1, ab, ab+1, ba, ba+1, bb, bb+1.
    assign g3[0] = grad(i_hash[0], x0, y0, z0);
    assign g3[1] = grad(i_hash[1], x0, y0, z1);
    assign g3[2] = grad(i_hash[2], x0, y1, z0);
    assign g3[3] = grad(i_hash[3], x0, y1, z1);
    assign g3[4] = grad(i_hash[4], x1, y0, z0);
    assign g3[5] = grad(i_hash[5], x1, y0, z1);
    assign g3[6] = grad(i_hash[6], x1, y1, z0);
    assign g3[7] = grad(i_hash[7], x1, y1, z1);

    assign n6  = lerp(r_w6, r_lo6, r_hi6);
    assign s6  = RW'(n6) + RW'(C_ONE);
    assign sh6 = (s6 >>> SHR) <<< SHL;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_g4    <= g3;
            r_v5    <= i_v;
            r_w5    <= i_w;
            r_l5[0] <= lerp(i_u, r_g4[0], r_g4[4]);
            r_l5[1] <= lerp(i_u, r_g4[2], r_g4[6]);
            r_l5[2] <= lerp(i_u, r_g4[1], r_g4[5]);
            r_l5[3] <= lerp(i_u, r_g4[3], r_g4[7]);
            r_w6    <= r_w5;
            r_lo6   <= lerp(r_v5, r_l5[0], r_l5[1]);
            r_hi6   <= lerp(r_v5, r_l5[2], r_l5[3]);
            priority if (s6 < 0) begin
                o_noise <= '0;
            end else if (sh6 > RW'(65535)) begin
                o_noise <= '1;
            end else begin
                o_noise <= sh6[OUT_W-1:0];
            end
        end
    end
endmodule
`default_nettype wire

[src/gradient_noise_3d_core.sv]
`default_nettype none
// Channel  | Direction | Payload
// i_in     | sink      | command, table_index, table_value, coord_x/y/z
// o_out    | source    | noise_value (only for evaluate items)
//
// One item is taken every clock while the output is not stalled; an evaluate
// item's result passes six pipeline stages and the output register.
// The three table lookup levels each read their own copies of the table.
// Reset (synchronous, active low) clears only the valid bits and the
// pending table-write flags; table contents stay undefined until written.
// A stalled output freezes the whole pipeline, so nothing is lost or repeated.
module gradient_noise_3d_core
    import gn3_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input wire logic  i_clk,
    input wire logic  i_rst_n,
    gn3_in_if.sink    i_in,
    gn3_out_if.source o_out
);
    localparam int F = FRAC_BITS;

    logic        en, acc;
    logic [6:1]  r_ev;
    logic        r_ov;
    t_tbl_req    req;
    logic [CELL_W-1:0]  hash [8];
    logic [F-1:0]       fx3, fy3, fz3;
    logic signed [F+1:0] u4, v4, w4;

    // The pipeline advances when the output register is empty or being taken.
    assign en          = !r_ov || o_out.ready;
    assign i_in.ready  = en;
    assign acc         = i_in.valid && en;
    assign o_out.valid = r_ov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ev <= '0;
            r_ov <= 1'b0;
        end else if (en) begin
            r_ev <= {r_ev[5:1], acc && (i_in.command == CMD_EVAL)};
            r_ov <= r_ev[6];
        end
    end

    assign req.load        = acc;
    assign req.command     = i_in.command;
    assign req.table_index = i_in.table_index;
    assign req.table_value = i_in.table_value;
    assign req.cell_x      = i_in.coord_x[F+CELL_W-1:F];
    assign req.cell_y      = i_in.coord_y[F+CELL_W-1:F];
    assign req.cell_z      = i_in.coord_z[F+CELL_W-1:F];

    gn3_hash u_hash (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_req  (req),
        .o_hash (hash)
    );

    gn3_fade #(.FRAC_BITS(F)) u_fade_x (
        .i_clk(i_clk), .i_en(en), .i_frac(i_in.coord_x[F-1:0]), .o_frac3(fx3), .o_fade(u4)
    );
    gn3_fade #(.FRAC_BITS(F)) u_fade_y (
        .i_clk(i_clk), .i_en(en), .i_frac(i_in.coord_y[F-1:0]), .o_frac3(fy3), .o_fade(v4)
    );
    gn3_fade #(.FRAC_BITS(F)) u_fade_z (
        .i_clk(i_clk), .i_en(en), .i_frac(i_in.coord_z[F-1:0]), .o_frac3(fz3), .o_fade(w4)
    );

    gn3_blend #(.FRAC_BITS(F)) u_blend (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_hash (hash),
        .i_fx   (fx3),
        .i_fy   (fy3),
        .i_fz   (fz3),
        .i_u    (u4),
        .i_v    (v4),
        .i_w    (w4),
        .o_noise(o_out.noise_value)
    );
endmodule
`default_nettype wire
